@@ hdl/snu_pkg.sv @@
// package for the sigmoid neuron unit: item kinds, widths and shared helpers
// no dependencies
package snu_pkg;

   localparam int MaxWeightsDefault = 64;
   localparam logic [31:0] WeightReset = 32'sd655360000;
   localparam logic [16:0] OneQ16 = 17'd65536;
   localparam logic [6:0] NumWeightsReset = 7'd64;
   localparam logic [23:0] LearningRateReset = 24'd5033;

   typedef enum logic [2:0] {
      KIND_SUM = 3'd0,
      KIND_SET_ERR = 3'd1,
      KIND_ADD_ERR = 3'd2,
      KIND_ADJUST = 3'd3,
      KIND_BACKPROP = 3'd4,
      KIND_SET_VAL = 3'd5,
      KIND_WRITE_W = 3'd6,
      KIND_NONE = 3'd7
   } kind_type;

   typedef enum logic {
      CSR_NUM_WEIGHTS = 1'b0,
      CSR_LEARNING_RATE = 1'b1
   } csr_index_type;

   // engine sequencer states
   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_SUM_RD, ST_SUM_MUL, ST_SUM_ACC, ST_SIGMOID,
      ST_ADJ_STEP, ST_ADJ_RD, ST_ADJ_WR, ST_BP_RD, ST_BP_MUL, ST_BP_OUT, ST_STATUS
   } state_type;

   // one queued request
   typedef struct packed {
      kind_type kind;
      logic signed [31:0] operand;
      logic [5:0] weight_index;
   } item_type;

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // four-segment piecewise sigmoid
   function automatic logic [16:0] sigmoid_q16(input logic signed [63:0] x);
      logic neg;
      logic [18:0] a;
      logic [16:0] y;
      neg = x[63];
      if (neg) a = (x < -64'sd327680) ? 19'd327680 : 19'((-x));
      else a = (x >= 64'sd327680) ? 19'd327680 : x[18:0];
      if (a >= 19'd327680) y = OneQ16;
      else if (a >= 19'd155648) y = 17'(a >> 5) + 17'd55296;
      else if (a >= 19'd65536) y = 17'(a >> 3) + 17'd40960;
      else y = 17'(a >> 2) + 17'd32768;
      if (neg) y = OneQ16 - y;
      return y;
   endfunction

endpackage

@@ hdl/snu_ram.sv @@
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module snu_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

@@ hdl/snu_front.sv @@
// front end: two-entry request queue between the stream input and the engine
// depends on snu_pkg
module snu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  snu_pkg::item_type  in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output snu_pkg::item_type  out_item
);
   snu_pkg::item_type q_ff [2];
   snu_pkg::item_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item = q_ff[0];

   // shift queue update
   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = in_item;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end
endmodule

@@ hdl/snu_back.sv @@
// back end: executes requests against weight ram, accumulator and error state
// depends on snu_pkg and snu_ram
module snu_back #(
   parameter int MaxWeights = snu_pkg::MaxWeightsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  snu_pkg::item_type  in_item,
   input  logic [6:0]         num_weights,
   input  logic [23:0]        learning_rate,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [87:0]        rsp_tdata,
   output logic               rsp_tlast
);
   localparam int AW = (MaxWeights > 1) ? $clog2(MaxWeights) : 1;
   localparam int CW = $clog2(MaxWeights + 1) + 1;
   localparam logic [CW-1:0] MaxW = CW'(MaxWeights);

   snu_pkg::state_type state_ff, state_in;
   snu_pkg::item_type item_ff, item_in;
   logic signed [63:0] sum_ff, sum_in;
   logic [CW-1:0] count_ff, count_in;
   logic signed [31:0] err_ff, err_in;
   logic [16:0] act_ff, act_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] step_ff, step_in;
   logic [AW-1:0] init_ff, init_in;
   logic valid_ff, valid_in;
   logic last_ff, last_in;
   logic signed [31:0] passed_ff, passed_in;
   logic [5:0] slot_ff, slot_in;
   logic [16:0] o_act_ff, o_act_in;
   logic signed [31:0] o_err_ff, o_err_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;
   logic [CW-1:0] n;
   logic [CW-1:0] cnt_next;
   logic out_free;

   snu_ram #(.Width(32), .Depth(MaxWeights)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // effective weight count
   always_comb begin
      if (num_weights == 7'd0) n = CW'(1);
      else if (CW'(num_weights) > MaxW) n = MaxW;
      else n = CW'(num_weights);
   end

   assign out_free = !valid_ff || rsp_tready;
   assign in_ready = (state_ff == snu_pkg::ST_IDLE);
   assign cnt_next = count_ff + CW'(1);

   // sequencer
   always_comb begin
      state_in = state_ff; item_in = item_ff; sum_in = sum_ff; count_in = count_ff;
      err_in = err_ff; act_in = act_ff; idx_in = idx_ff; prod_in = prod_ff;
      step_in = step_ff; init_in = init_ff;
      valid_in = valid_ff && !rsp_tready; last_in = last_ff; passed_in = passed_ff;
      slot_in = slot_ff; o_act_in = o_act_ff; o_err_in = o_err_ff;
      wr_en = 1'b0; wr_addr = idx_ff; wr_data = 32'd0; rd_addr = idx_ff;
      case (state_ff)
         snu_pkg::ST_INIT: begin
            wr_en = 1'b1; wr_addr = init_ff; wr_data = snu_pkg::WeightReset;
            init_in = init_ff + AW'(1);
            if (32'(init_ff) == 32'(MaxWeights - 1)) state_in = snu_pkg::ST_IDLE;
         end
         snu_pkg::ST_IDLE: begin
            if (in_valid) begin
               item_in = in_item;
               idx_in = '0;
               case (in_item.kind)
                  snu_pkg::KIND_SUM: begin
                     rd_addr = count_ff[AW-1:0];
                     state_in = snu_pkg::ST_SUM_RD;
                  end
                  snu_pkg::KIND_SET_ERR: begin
                     err_in = in_item.operand; state_in = snu_pkg::ST_STATUS;
                  end
                  snu_pkg::KIND_ADD_ERR: begin
                     err_in = snu_pkg::sat32(64'(err_ff) + 64'(in_item.operand));
                     state_in = snu_pkg::ST_STATUS;
                  end
                  snu_pkg::KIND_ADJUST: state_in = snu_pkg::ST_ADJ_STEP;
                  snu_pkg::KIND_BACKPROP: state_in = snu_pkg::ST_BP_RD;
                  snu_pkg::KIND_SET_VAL: begin
                     if (in_item.operand[31]) act_in = 17'd0;
                     else if (in_item.operand > 32'sd65536) act_in = snu_pkg::OneQ16;
                     else act_in = in_item.operand[16:0];
                     state_in = snu_pkg::ST_STATUS;
                  end
                  snu_pkg::KIND_WRITE_W: begin
                     if (32'(in_item.weight_index) < 32'(MaxWeights)) begin
                        wr_en = 1'b1; wr_addr = AW'(in_item.weight_index);
                        wr_data = in_item.operand;
                     end
                     state_in = snu_pkg::ST_STATUS;
                  end
                  default: state_in = snu_pkg::ST_STATUS;
               endcase
            end
         end
         snu_pkg::ST_SUM_RD: begin
            rd_addr = count_ff[AW-1:0];
            state_in = snu_pkg::ST_SUM_MUL;
         end
         snu_pkg::ST_SUM_MUL: begin
            prod_in = 64'(item_ff.operand) * 64'($signed(rd_data));
            state_in = snu_pkg::ST_SUM_ACC;
         end
         snu_pkg::ST_SUM_ACC: begin
            if (count_ff < MaxW) sum_in = sum_ff + (prod_ff >>> 16);
            count_in = cnt_next;
            state_in = (cnt_next >= n) ? snu_pkg::ST_SIGMOID : snu_pkg::ST_STATUS;
         end
         snu_pkg::ST_SIGMOID: begin
            act_in = snu_pkg::sigmoid_q16(sum_ff);
            sum_in = '0; count_in = '0;
            state_in = snu_pkg::ST_STATUS;
         end
         snu_pkg::ST_ADJ_STEP: begin
            prod_in = 64'($signed({1'b0, learning_rate})) * 64'(err_ff);
            state_in = snu_pkg::ST_ADJ_RD;
         end
         snu_pkg::ST_ADJ_RD: begin
            step_in = prod_ff[55:24];
            rd_addr = idx_ff;
            state_in = snu_pkg::ST_ADJ_WR;
         end
         snu_pkg::ST_ADJ_WR: begin
            wr_en = 1'b1; wr_addr = idx_ff;
            wr_data = snu_pkg::sat32(64'($signed(rd_data)) + 64'(step_ff));
            idx_in = idx_ff + AW'(1);
            state_in = (CW'(idx_ff) + CW'(1) >= n) ? snu_pkg::ST_STATUS
                                                   : snu_pkg::ST_ADJ_RD;
         end
         snu_pkg::ST_BP_RD: begin
            rd_addr = idx_ff;
            state_in = snu_pkg::ST_BP_MUL;
         end
         snu_pkg::ST_BP_MUL: begin
            prod_in = 64'(err_ff) * 64'($signed(rd_data));
            state_in = snu_pkg::ST_BP_OUT;
         end
         snu_pkg::ST_BP_OUT: begin
            if (out_free) begin
               valid_in = 1'b1;
               passed_in = snu_pkg::sat32(prod_ff >>> 16);
               slot_in = 6'(idx_ff);
               last_in = (CW'(idx_ff) + CW'(1) >= n);
               o_act_in = act_ff; o_err_in = err_ff;
               idx_in = idx_ff + AW'(1);
               state_in = last_in ? snu_pkg::ST_IDLE : snu_pkg::ST_BP_RD;
            end
         end
         snu_pkg::ST_STATUS: begin
            if (out_free) begin
               valid_in = 1'b1; passed_in = '0; slot_in = '0; last_in = 1'b1;
               o_act_in = act_ff; o_err_in = err_ff;
               state_in = snu_pkg::ST_IDLE;
            end
         end
         default: state_in = snu_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in; idx_ff <= idx_in; prod_ff <= prod_in; step_ff <= step_in;
      last_ff <= last_in; passed_ff <= passed_in; slot_ff <= slot_in;
      o_act_ff <= o_act_in; o_err_ff <= o_err_in;
      if (reset) begin
         state_ff <= snu_pkg::ST_INIT; sum_ff <= '0; count_ff <= '0; err_ff <= '0;
         act_ff <= '0; init_ff <= '0; valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; sum_ff <= sum_in; count_ff <= count_in;
         err_ff <= err_in; act_ff <= act_in; init_ff <= init_in; valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tdata = {1'b0, slot_ff, passed_ff, o_err_ff, o_act_ff};
endmodule

@@ hdl/sigmoid_neuron_unit_core.sv @@
// top level of the sigmoid neuron unit: config registers, front queue, back engine
// depends on snu_pkg, snu_front, snu_back
//
// Usage:
// - req_ stream carries one request: tdata {weight_index, operand, kind}.
// - rsp_ stream carries results: tdata {slot, passed_error, error_now,
//   neuron_value}; tlast marks the final result of a request.
// - csr_ port writes num_weights (index 0) and learning_rate (index 1).
// - Requests pass a two-entry queue and run in the engine one at a time.
// - Engine steps per request: status kinds go straight to the result; a sum
//   element passes ram read, multiply and accumulate, and the element that
//   completes n weights also runs the sigmoid before its result.
// - Adjust first forms the step; then adjust and backprop walk the slots:
//   each slot needs a ram read, then a write or a multiply, one slot at a time.
// - After reset the engine sweeps the weight ram, writing 10000.0 to every
//   slot; requests queue but do not run meanwhile.
// - A stalled rsp_ holds its result; the engine waits, then req_ fills up.
module sigmoid_neuron_unit_core #(
   parameter int MaxWeights = snu_pkg::MaxWeightsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // kind[2:0], operand[34:3], weight_index[40:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // neuron_value[16:0], error_now[48:17],
                                    // passed_error[80:49], slot[86:81]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_data
);
   logic [6:0] num_weights_ff;
   logic [23:0] learning_rate_ff;
   snu_pkg::item_type req_item, q_item;
   logic q_valid, q_ready;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_weights_ff <= snu_pkg::NumWeightsReset;
         learning_rate_ff <= snu_pkg::LearningRateReset;
      end else if (csr_valid) begin
         case (csr_index)
            snu_pkg::CSR_NUM_WEIGHTS: num_weights_ff <= csr_data[6:0];
            snu_pkg::CSR_LEARNING_RATE: learning_rate_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_item.kind = snu_pkg::kind_type'(req_tdata[2:0]);
   assign req_item.operand = req_tdata[34:3];
   assign req_item.weight_index = req_tdata[40:35];

   snu_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(req_item), .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   snu_back #(.MaxWeights(MaxWeights)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_ready(q_ready),
      .in_item(q_item), .num_weights(num_weights_ff), .learning_rate(learning_rate_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );
endmodule
